### rtl/lfod_pkg.sv
package lfod_pkg;

    // Wheel direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [7:0] DUTY_MAX = 8'd255;

    // Configuration register indexes
    localparam logic [2:0] REG_FWD_SPEED        = 3'd0;
    localparam logic [2:0] REG_TURN_RATE_SMALL  = 3'd1;
    localparam logic [2:0] REG_TURN_RATE_LARGE  = 3'd2;
    localparam logic [2:0] REG_TURN_RATE_SEARCH = 3'd3;
    localparam logic [2:0] REG_HOLD_STRAIGHT    = 3'd4;
    localparam logic [2:0] REG_HOLD_SMALL       = 3'd5;
    localparam logic [2:0] REG_HOLD_LARGE       = 3'd6;
    localparam logic [2:0] REG_HOLD_SEARCH      = 3'd7;

    // Line codes, bit3 outer left .. bit0 outer right, 1 = line seen
    localparam logic [3:0] CODE_NONE        = 4'b0000;
    localparam logic [3:0] CODE_CENTER      = 4'b0110;
    localparam logic [3:0] CODE_ALL         = 4'b1111;
    localparam logic [3:0] CODE_INNER_LEFT  = 4'b0100;
    localparam logic [3:0] CODE_OUTER_LEFT  = 4'b1000;
    localparam logic [3:0] CODE_BENT_LEFT   = 4'b1100;
    localparam logic [3:0] CODE_WIDE_LEFT   = 4'b1110;
    localparam logic [3:0] CODE_INNER_RIGHT = 4'b0010;
    localparam logic [3:0] CODE_OUTER_RIGHT = 4'b0001;
    localparam logic [3:0] CODE_BENT_RIGHT  = 4'b0011;
    localparam logic [3:0] CODE_WIDE_RIGHT  = 4'b0111;

    // Irregular patterns, handled as a spin without touching the line side
    localparam logic [3:0] CODE_SPLIT_IL_OR = 4'b0101;
    localparam logic [3:0] CODE_OUTERS      = 4'b1001;
    localparam logic [3:0] CODE_SPLIT_OL_IR = 4'b1010;
    localparam logic [3:0] CODE_GAP_LEFT    = 4'b1011;
    localparam logic [3:0] CODE_GAP_RIGHT   = 4'b1101;

    // Reciprocal of ten in 0.16 fixed point, exact for inputs well past 2303
    localparam logic [12:0] RECIP10 = 13'd6554;

    typedef struct packed {
        logic [7:0] duty;
        logic [1:0] dir;
    } t_wheel;

    // Tenths to duty and direction: round half away from zero, divide by ten, saturate
    function automatic t_wheel f_wheel(input logic signed [12:0] tenths);
        logic [12:0] mag;
        logic [25:0] prod;
        logic [8:0]  q;
        t_wheel      res;
        mag  = tenths[12] ? 13'(-tenths) : 13'(tenths);
        prod = 26'(mag + 13'd5) * 26'(RECIP10);
        q    = prod[24:16];
        res.duty = (q > {1'b0, DUTY_MAX}) ? DUTY_MAX : q[7:0];
        if (res.duty == 8'd0) begin
            res.dir = DIR_STOP;
        end else begin
            res.dir = tenths[12] ? DIR_REV : DIR_FWD;
        end
        return res;
    endfunction

endpackage

### rtl/line_follow_omni_drive.sv
// Line follower drive for a three-wheel omni base.
//
// Input channel: i_valid / o_stall carry one beat of four raw active-low
// line-sensor levels. Output channel: o_valid / i_stall carry one beat of
// duty and direction for the left front, right front and rear wheels, plus
// the hold time in milliseconds for that drive.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx; write
// only while no beat is in flight.
// The sensor beat lands in an input register; the decode and wheel arithmetic
// (one constant multiply per wheel) then fill the result register. Throughput
// is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, and o_stall rises only once both are full.
// Reset (synchronous, active low) empties both registers, restores the
// register defaults and sets the remembered line side to left.
module line_follow_omni_drive
    import lfod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_sensor_levels,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [9:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_left_front_duty,
    output logic [1:0] o_left_front_dir,
    output logic [7:0] o_right_front_duty,
    output logic [1:0] o_right_front_dir,
    output logic [7:0] o_rear_duty,
    output logic [1:0] o_rear_dir,
    output logic [7:0] o_hold_ms
);

    logic [7:0] r_fwd_speed;
    logic [9:0] r_turn_small;
    logic [9:0] r_turn_large;
    logic [9:0] r_turn_search;
    logic [7:0] r_hold_straight;
    logic [7:0] r_hold_small;
    logic [7:0] r_hold_large;
    logic [7:0] r_hold_search;
    logic       r_last_side;
    logic       n_last_side;

    logic       r_in_valid;
    logic [3:0] r_in_levels;
    logic       r_out_valid;
    t_wheel     r_lf;
    t_wheel     r_rf;
    t_wheel     r_rear;
    logic [7:0] r_hold;

    logic       out_free;
    logic       advance;
    logic [3:0] code;
    logic [7:0] vy;
    logic signed [10:0] w;
    logic [7:0] n_hold;
    logic [10:0] vy5;
    logic signed [12:0] lf_tenths;
    logic signed [12:0] rf_tenths;
    logic signed [12:0] rear_tenths;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_speed     <= 8'd80;
            r_turn_small    <= 10'd15;
            r_turn_large    <= 10'd20;
            r_turn_search   <= 10'd300;
            r_hold_straight <= 8'd5;
            r_hold_small    <= 8'd2;
            r_hold_large    <= 8'd3;
            r_hold_search   <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FWD_SPEED:        r_fwd_speed     <= i_cfg_data[7:0];
                REG_TURN_RATE_SMALL:  r_turn_small    <= i_cfg_data;
                REG_TURN_RATE_LARGE:  r_turn_large    <= i_cfg_data;
                REG_TURN_RATE_SEARCH: r_turn_search   <= i_cfg_data;
                REG_HOLD_STRAIGHT:    r_hold_straight <= i_cfg_data[7:0];
                REG_HOLD_SMALL:       r_hold_small    <= i_cfg_data[7:0];
                REG_HOLD_LARGE:       r_hold_large    <= i_cfg_data[7:0];
                REG_HOLD_SEARCH:      r_hold_search   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: advance the input beat whenever the result register is free
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_levels <= i_sensor_levels;
        end
    end

    // Decode the line code into forward speed, turn rate, hold and line side
    always_comb begin
        code        = ~r_in_levels;
        vy          = r_fwd_speed;
        w           = 11'sd0;
        n_hold      = r_hold_straight;
        n_last_side = r_last_side;
        case (code)
            CODE_CENTER, CODE_ALL: begin
            end
            CODE_INNER_LEFT: begin
                n_last_side = 1'b0;
                w           = -$signed({1'b0, r_turn_small});
                n_hold      = r_hold_small;
            end
            CODE_OUTER_LEFT, CODE_BENT_LEFT, CODE_WIDE_LEFT: begin
                n_last_side = 1'b0;
                w           = -$signed({1'b0, r_turn_large});
                n_hold      = r_hold_large;
            end
            CODE_INNER_RIGHT: begin
                n_last_side = 1'b1;
                w           = $signed({1'b0, r_turn_small});
                n_hold      = r_hold_small;
            end
            CODE_OUTER_RIGHT, CODE_BENT_RIGHT, CODE_WIDE_RIGHT: begin
                n_last_side = 1'b1;
                w           = $signed({1'b0, r_turn_large});
                n_hold      = r_hold_large;
            end
            default: begin
                // lost line or irregular code: spin toward the last side seen
                vy     = 8'd0;
                w      = r_last_side ? $signed({1'b0, r_turn_search})
                                     : -$signed({1'b0, r_turn_search});
                n_hold = (code == CODE_NONE) ? r_hold_search : r_hold_straight;
            end
        endcase
    end

    // Wheel speeds in tenths
    assign vy5         = 11'({3'b000, vy} * 11'd5);
    assign lf_tenths   = $signed({2'b00, vy5}) + 13'(w);
    assign rf_tenths   = $signed({2'b00, vy5}) - 13'(w);
    assign rear_tenths = 13'(w);

    // Remembered line side updates as the beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_side <= 1'b0;
        end else if (advance) begin
            r_last_side <= n_last_side;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lf   <= f_wheel(lf_tenths);
            r_rf   <= f_wheel(rf_tenths);
            r_rear <= f_wheel(rear_tenths);
            r_hold <= n_hold;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_left_front_duty  = r_lf.duty;
    assign o_left_front_dir   = r_lf.dir;
    assign o_right_front_duty = r_rf.duty;
    assign o_right_front_dir  = r_rf.dir;
    assign o_rear_duty        = r_rear.duty;
    assign o_rear_dir         = r_rear.dir;
    assign o_hold_ms          = r_hold;

endmodule

### rtl/lfod_check.sv
module lfod_check
    import lfod_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_left_front_duty,
    input logic [1:0] o_left_front_dir,
    input logic [7:0] o_right_front_duty,
    input logic [1:0] o_right_front_dir,
    input logic [7:0] o_rear_duty,
    input logic [1:0] o_rear_dir,
    input logic [7:0] o_hold_ms
);

    // A stalled result beat holds its wheel duties and hold time
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_left_front_duty)
            && $stable(o_right_front_duty) && $stable(o_rear_duty)
            && $stable(o_hold_ms)))
        else $error("result beat changed under stall");

    // Input is only stalled when a finished result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the result register");

    // An accepted input beat reaches the result register as a valid result
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> ##2 o_valid)
        else $error("accepted beat did not reach the result register");

    // Stop direction exactly when duty is zero
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_left_front_duty == 8'd0) == (o_left_front_dir == DIR_STOP))
            && ((o_right_front_duty == 8'd0) == (o_right_front_dir == DIR_STOP))
            && ((o_rear_duty == 8'd0) == (o_rear_dir == DIR_STOP))))
        else $error("wheel direction disagrees with duty");

    // Direction codes stay within stop, forward and reverse
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_left_front_dir != 2'd3) && (o_right_front_dir != 2'd3)
            && (o_rear_dir != 2'd3)))
        else $error("unused direction code on output");

endmodule

bind line_follow_omni_drive lfod_check u_lfod_check (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_left_front_duty  (o_left_front_duty),
    .o_left_front_dir   (o_left_front_dir),
    .o_right_front_duty (o_right_front_duty),
    .o_right_front_dir  (o_right_front_dir),
    .o_rear_duty        (o_rear_duty),
    .o_rear_dir         (o_rear_dir),
    .o_hold_ms          (o_hold_ms)
);
